>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the averager RTL
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check
`define CHECK_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen at a clock edge
`define CHECK_NEVER(label, cond, msg) \
    `CHECK_PROP(label, !(cond), msg)

`endif

>>> hw/rtl/abacd_pkg.sv
// ----------------------------------------------------------------------------
// abacd_pkg
// Shared widths, register indexes, curve codes and types of the
// per-channel block averager.
// ----------------------------------------------------------------------------
package abacd_pkg;

    localparam int CHAN_W     = 4;
    localparam int SAMPLE_W   = 10;
    localparam int SUM_W      = 16;
    localparam int THR_W      = 10;
    localparam int MODE_W     = 3;
    localparam int MAP_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE      = 1'd1;

    // Output curve codes
    localparam logic [MODE_W-1:0] MODE_BYTE_FADER  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BYTE_VOLUME = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BYTE_RAW    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WORD_FADER  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WORD_VOLUME = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WORD_RAW    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ZERO        = 3'd6;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 10'd4;
    localparam logic [MODE_W-1:0] MODE_RESET      = MODE_BYTE_RAW;

    // Completed window handed from front to back
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [SUM_W-1:0]  sum;
    } q_item_t;

    typedef struct packed {
        logic [THR_W-1:0]  change_threshold;
        logic [MODE_W-1:0] output_mode;
    } cfg_t;

endpackage

>>> hw/rtl/adc_block_average_change_detect.sv
// A window's last sample queues it; it then moves through the stage A and stage B registers.
// One sample beat per cycle unless item_stall is set; per-channel running sums are registered.
// Back end: one window per cycle unless stalled; one 16x17 multiply, then compare and curve.
// A four-entry queue between the two keeps sample intake going while results are stalled.
// Reset (rst_n, async, active low) clears sums, counts, references, queue; no clearing pass.
// ----------------------------------------------------------------------------
// adc_block_average_change_detect
// Per-channel block averager with change flag and selectable output curve.
// ----------------------------------------------------------------------------
module adc_block_average_change_detect
    import abacd_pkg::*;
#(
    parameter int WINDOW   = 8,
    parameter int CHANNELS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [CHAN_W-1:0]     channel,
    input  logic [SAMPLE_W-1:0]   sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [CHAN_W-1:0]     channel_res,
    output logic [SAMPLE_W-1:0]   average,
    output logic                  changed,
    output logic [MAP_W-1:0]      mapped_value
);

    logic [THR_W-1:0]  threshold_reg;
    logic [MODE_W-1:0] mode_reg;
    cfg_t              cfg;

    logic    q_push;
    q_item_t q_push_item;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    q_item_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            mode_reg      <= MODE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CHANGE_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                REG_OUTPUT_MODE:      mode_reg      <= cfg_data[MODE_W-1:0];
                default:              ;
            endcase
        end
    end

    assign cfg = '{change_threshold: threshold_reg, output_mode: mode_reg};

    abacd_front #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .channel    (channel),
        .sample     (sample),
        .q_full     (q_full),
        .push       (q_push),
        .push_item  (q_push_item)
    );

    abacd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    abacd_back #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .channel_res  (channel_res),
        .average      (average),
        .changed      (changed),
        .mapped_value (mapped_value)
    );

endmodule

>>> hw/rtl/abacd_front.sv
// ----------------------------------------------------------------------------
// abacd_front
// Accepts sample beats, keeps the running sum and count of each channel and
// hands each completed window to the queue.
// ----------------------------------------------------------------------------
module abacd_front
    import abacd_pkg::*;
#(
    parameter int WINDOW   = 8,
    parameter int CHANNELS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [CHAN_W-1:0]   channel,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                q_full,
    output logic                push,
    output q_item_t             push_item
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

    logic [SUM_W-1:0] sum_reg [CHANNELS];
    logic [CNT_W-1:0] cnt_reg [CHANNELS];

    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             take;
    logic             last_beat;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] cnt_next;

    assign item_stall = q_full;
    assign idx        = IDX_W'(channel);
    assign in_range   = 32'(channel) < CHANNELS;
    assign take       = item_valid && !q_full && in_range;
    assign sum_next   = sum_reg[idx] + SUM_W'(sample);
    assign last_beat  = cnt_reg[idx] == CNT_LAST;
    assign cnt_next   = cnt_reg[idx] + CNT_W'(1);

    assign push      = take && last_beat;
    assign push_item = '{channel: channel, sum: sum_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            // restart the window once its last beat is out
            if (last_beat)
            begin
                sum_reg[idx] <= '0;
                cnt_reg[idx] <= '0;
            end
            else
            begin
                sum_reg[idx] <= sum_next;
                cnt_reg[idx] <= cnt_next;
            end
        end
    end

endmodule

>>> hw/rtl/abacd_queue.sv
// ----------------------------------------------------------------------------
// abacd_queue
// Small FIFO of completed windows between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abacd_queue
    import abacd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output logic    empty,
    output q_item_t head
);

    q_item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    assign full  = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    `CHECK_NEVER(a_push_full, push && full, "queue push while full")
    `CHECK_NEVER(a_pop_empty, pop && empty, "queue pop while empty")
    `CHECK_PROP(a_count_track, count_reg == $past(count_next), "queue count lost a beat")

endmodule

>>> hw/rtl/abacd_back.sv
// ----------------------------------------------------------------------------
// abacd_back
// Turns completed window sums into results: mean by reciprocal multiply,
// change detection against the last mean flagged as changed, and the output curve.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abacd_back
    import abacd_pkg::*;
#(
    parameter int WINDOW   = 8,
    parameter int CHANNELS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                q_empty,
    input  q_item_t             q_head,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [CHAN_W-1:0]   channel_res,
    output logic [SAMPLE_W-1:0] average,
    output logic                changed,
    output logic [MAP_W-1:0]    mapped_value
);

    localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // sum / WINDOW == (sum * DIV_MUL) >> DIV_SHIFT for every 16-bit sum
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int MUL_W     = SUM_W + 1;
    localparam logic [MUL_W-1:0] DIV_MUL =
        MUL_W'((2**DIV_SHIFT + WINDOW - 1) / WINDOW);
    localparam int PROD_W    = SUM_W + MUL_W;

    localparam int FADER_DIV = 125;

    // stage A: mean
    logic                a_valid_reg;
    logic [CHAN_W-1:0]   a_ch_reg;
    logic [SAMPLE_W-1:0] a_avg_reg;

    // stage B: result register
    logic                result_valid_reg;
    logic [CHAN_W-1:0]   channel_res_reg;
    logic [SAMPLE_W-1:0] average_reg;
    logic                changed_reg;
    logic [MAP_W-1:0]    mapped_value_reg;

    logic [SAMPLE_W-1:0] last_rep_reg [CHANNELS];

    logic                b_ready;
    logic                a_ready;
    logic [PROD_W-1:0]   product;
    logic [IDX_W-1:0]    a_idx;
    logic [SAMPLE_W-1:0] last_rep;
    logic [SAMPLE_W-1:0] diff;
    logic                chg;

    logic [6:0]          byte_x;
    logic [7:0]          byte_fader;
    logic [7:0]          byte_volume;
    logic [3:0]          fader_quot;
    logic [MAP_W-1:0]    word_fader;
    logic [MAP_W-1:0]    word_volume;
    logic [MAP_W-1:0]    map_next;

    assign b_ready = !result_valid_reg || !result_stall;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = !q_empty && a_ready;
    assign product = PROD_W'(q_head.sum) * PROD_W'(DIV_MUL);

    assign a_idx    = IDX_W'(a_ch_reg);
    assign last_rep = last_rep_reg[a_idx];
    assign diff     = (a_avg_reg >= last_rep) ? a_avg_reg - last_rep : last_rep - a_avg_reg;
    assign chg      = diff > cfg.change_threshold;

    // floor(x / 125) for a 10-bit mean
    always_comb
    begin
        fader_quot = '0;
        for (int k = 1; k <= 8; k++)
        begin
            if (a_avg_reg >= SAMPLE_W'(FADER_DIV * k))
                fader_quot = fader_quot + 4'd1;
        end
    end

    assign byte_x      = a_avg_reg[SAMPLE_W-1:3];
    assign byte_fader  = {1'b0, byte_x} + ((byte_x >= 7'(FADER_DIV)) ? 8'd1 : 8'd0);
    assign byte_volume = 8'd255 - a_avg_reg[SAMPLE_W-1:2];
    assign word_fader  = MAP_W'(a_avg_reg) + MAP_W'(fader_quot);
    assign word_volume = 11'd1024 - MAP_W'(a_avg_reg);

    always_comb
    begin
        case (cfg.output_mode)
            MODE_BYTE_FADER:
            begin
                if (byte_fader < 8'd2)
                    map_next = '0;
                else if (byte_fader > 8'd127)
                    map_next = 11'd127;
                else
                    map_next = MAP_W'(byte_fader);
            end
            MODE_BYTE_VOLUME:
                map_next = (byte_volume inside {[8'd125:8'd129]}) ? 11'd127
                                                                  : MAP_W'(byte_volume);
            MODE_BYTE_RAW:
                map_next = MAP_W'(a_avg_reg[SAMPLE_W-1:2]);
            MODE_WORD_FADER:
            begin
                if (word_fader < 11'd8)
                    map_next = '0;
                else if (word_fader > 11'd1024)
                    map_next = 11'd1024;
                else
                    map_next = word_fader;
            end
            MODE_WORD_VOLUME:
                map_next = (word_volume inside {[11'd507:11'd517]}) ? 11'd512 : word_volume;
            MODE_WORD_RAW:
                map_next = MAP_W'(a_avg_reg);
            default:
                map_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_ch_reg  <= q_head.channel;
            a_avg_reg <= product[DIV_SHIFT +: SAMPLE_W];
        end
        if (b_ready && a_valid_reg)
        begin
            channel_res_reg  <= a_ch_reg;
            average_reg      <= a_avg_reg;
            changed_reg      <= chg;
            mapped_value_reg <= map_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
                last_rep_reg[i] <= '0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= pop;
            if (b_ready)
                result_valid_reg <= a_valid_reg;
            // move the reference only when the mean really moved
            if (b_ready && a_valid_reg && chg)
                last_rep_reg[a_idx] <= a_avg_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign channel_res  = channel_res_reg;
    assign average      = average_reg;
    assign changed      = changed_reg;
    assign mapped_value = mapped_value_reg;

    `CHECK_NEVER(a_map_range, result_valid && (mapped_value > 11'd1024), "mapped value too large")

endmodule
